[design/hbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants, types and helpers of the heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int unsigned MAX_COLUMNS   = 128;
  localparam int unsigned MAX_ROWS      = 128;
  localparam int unsigned FRACTION_BITS = 8;

  localparam int unsigned COL_W    = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned IDX_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned SIZE_W   = IDX_W + 1;
  localparam int unsigned FRAC_W   = FRACTION_BITS;
  localparam int unsigned POS_W    = IDX_W + FRAC_W;
  localparam int unsigned ADDR_W   = $clog2(MAX_ROWS * MAX_COLUMNS);
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned WORLD_W  = 24;
  localparam int unsigned INV_W    = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned GRID_W   = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned MODE_W   = 1;
  localparam int unsigned CELL_W   = 7;

  localparam logic [MODE_W-1:0] MODE_WRITE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_DEPTH  = 3'd1,
    CFG_INV_SCALE_X = 3'd2,
    CFG_INV_SCALE_Z = 3'd3,
    CFG_HEIGHT_GAIN = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  idx1;
    logic [FRAC_W-1:0] frac;
  } gpos_t;

  typedef struct packed {
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       row_en;
    logic       mix_en;
    logic       gain_en;
  } blend_ctl_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [GRID_W-1:0] v,
                                                   input int unsigned hi);
    logic [SIZE_W-1:0] r;
    if (int'(v) < 2) begin
      r = SIZE_W'(2);
    end else if (int'(v) > int'(hi)) begin
      r = SIZE_W'(hi);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[design/hbs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_in_if
// Input channel: grid writes and height queries.
// ----------------------------------------------------------------------------
interface hbs_in_if;
  import hbs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [CELL_W-1:0]          cell_column;
  logic [CELL_W-1:0]          cell_row;
  logic signed [HEIGHT_W-1:0] cell_height;
  logic signed [WORLD_W-1:0]  world_x;
  logic signed [WORLD_W-1:0]  world_z;

  modport source (output valid, mode, cell_column, cell_row, cell_height, world_x, world_z,
                  input ready);
  modport sink (input valid, mode, cell_column, cell_row, cell_height, world_x, world_z,
                output ready);
endinterface

[design/hbs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_out_if
// Output channel: sampled heights.
// ----------------------------------------------------------------------------
interface hbs_out_if;
  import hbs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sampled_height;

  modport source (output valid, sampled_height, input ready);
  modport sink (input valid, sampled_height, output ready);
endinterface

[design/hbs_height_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_height_mem
// Height store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hbs_height_mem import hbs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic signed [HEIGHT_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic signed [HEIGHT_W-1:0] rdata_o
);

  logic signed [HEIGHT_W-1:0] mem [MAX_ROWS * MAX_COLUMNS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[design/hbs_grid_pos.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_grid_pos
// One axis: world coordinate times inverse scale, centred and clamped to
// the grid, split into cell, far cell and fraction.
// ----------------------------------------------------------------------------
module hbs_grid_pos import hbs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic signed [WORLD_W-1:0] world_i,
  input  logic [INV_W-1:0]          inv_i,
  input  logic [SIZE_W-1:0]         size_i,
  output gpos_t                     pos_o
);

  localparam int unsigned PROD_W = WORLD_W + INV_W + 1;
  localparam int unsigned T_W    = PROD_W + 1;
  localparam int unsigned SHIFT  = 16 - FRAC_W;
  localparam int unsigned Q_W    = T_W - 1 - SHIFT;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [T_W-1:0]    t;
  logic [Q_W-1:0]           q;
  logic [Q_W-1:0]           lim;
  logic [POS_W-1:0]         pos;
  logic [SIZE_W-1:0]        idx_inc;
  logic [SIZE_W-1:0]        size_m1;

  assign prod_d = world_i * $signed({1'b0, inv_i});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // add half the grid size at 16 fraction bits
  assign t       = T_W'(prod_q) + $signed(T_W'({size_i, 15'd0}));
  assign q       = t[T_W-2:SHIFT];
  assign size_m1 = size_i - SIZE_W'(1);
  assign lim     = Q_W'({size_m1, {FRAC_W{1'b0}}});

  always_comb begin
    if (t[T_W-1] || (t == '0)) begin
      pos = '0;
    end else if (q > lim) begin
      pos = POS_W'(lim);
    end else begin
      pos = q[POS_W-1:0];
    end
  end

  assign idx_inc    = SIZE_W'(pos[POS_W-1:FRAC_W]) + SIZE_W'(1);
  assign pos_o.idx  = pos[POS_W-1:FRAC_W];
  assign pos_o.frac = pos[FRAC_W-1:0];
  assign pos_o.idx1 = (idx_inc < size_i) ? idx_inc[IDX_W-1:0] : size_m1[IDX_W-1:0];

endmodule

[design/hbs_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_blend
// Bilinear blend of four neighbour heights, height gain and saturation.
// ----------------------------------------------------------------------------
module hbs_blend import hbs_pkg::*; (
  input  logic                       clk_i,
  input  blend_ctl_t                 ctl_i,
  input  logic signed [HEIGHT_W-1:0] rdata_i,
  input  logic [FRAC_W-1:0]          fx_i,
  input  logic [FRAC_W-1:0]          fz_i,
  input  logic signed [GAIN_W-1:0]   gain_i,
  output logic signed [OUT_W-1:0]    result_o
);

  localparam int unsigned RW   = HEIGHT_W + FRAC_W + 2;
  localparam int unsigned MW   = HEIGHT_W + 2 * FRAC_W + 1;
  localparam int unsigned GW   = MW + GAIN_W;
  localparam int unsigned SH_W = GW - 2 * FRAC_W;

  logic signed [HEIGHT_W-1:0] h_q [4];
  logic [FRAC_W:0]            wx0, wz0;
  logic signed [FRAC_W+1:0]   wx0_s, wz0_s, fx_s, fz_s;
  logic signed [RW-1:0]       row0_d, row1_d, row0_q, row1_q;
  logic signed [MW-1:0]       mix_d, mix_q;
  logic signed [GW-1:0]       gain_d, gain_q;
  logic [SH_W-1:0]            sh;

  assign wx0   = (FRAC_W+1)'(1) << FRAC_W;
  assign wz0   = (FRAC_W+1)'(1) << FRAC_W;
  assign wx0_s = $signed({1'b0, wx0 - (FRAC_W+1)'(fx_i)});
  assign wz0_s = $signed({1'b0, wz0 - (FRAC_W+1)'(fz_i)});
  assign fx_s  = $signed({2'b00, fx_i});
  assign fz_s  = $signed({2'b00, fz_i});

  assign row0_d = h_q[0] * wx0_s + h_q[1] * fx_s;
  assign row1_d = h_q[2] * wx0_s + h_q[3] * fx_s;
  assign mix_d  = row0_q * wz0_s + row1_q * fz_s;
  assign gain_d = mix_q * gain_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_en) begin
      h_q[ctl_i.cap_sel] <= rdata_i;
    end
    if (ctl_i.row_en) begin
      row0_q <= row0_d;
      row1_q <= row1_d;
    end
    if (ctl_i.mix_en) begin
      mix_q <= mix_d;
    end
    if (ctl_i.gain_en) begin
      gain_q <= gain_d;
    end
  end

  // floor shift, then saturate to the 32-bit range
  assign sh = gain_q[GW-1:2*FRAC_W];

  always_comb begin
    if ((&sh[SH_W-1:OUT_W-1]) || !(|sh[SH_W-1:OUT_W-1])) begin
      result_o = $signed(sh[OUT_W-1:0]);
    end else if (sh[SH_W-1]) begin
      result_o = $signed({1'b1, {(OUT_W-1){1'b0}}});
    end else begin
      result_o = $signed({1'b0, {(OUT_W-1){1'b1}}});
    end
  end

endmodule

[design/heightmap_bilinear_sampler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_core
// Height grid with bilinear sampling, gain and saturated Q24.8 output.
// ----------------------------------------------------------------------------
// A write item is stored at once. A query runs from acceptance to a loaded
// output register in these steps: form the grid products, clamp the
// position, four reads through the single read port of the height memory
// (one neighbour per cycle, registered read data), then the row blend, the
// column blend and the gain multiply. The input is taken again as soon as
// the query has left the datapath, while the result may still wait in the
// output register. The height memory has no reset; every entry must be
// written before a query touches it.
module heightmap_bilinear_sampler_core import hbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  hbs_in_if.sink                in_i,
  hbs_out_if.source             out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_RD0, S_RD1, S_RD2, S_RD3, S_CAP, S_ROW, S_MIX, S_GAIN, S_OUT
  } state_e;

  state_e                   state_q;
  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  out_height_q;

  logic [GRID_W-1:0]        grid_width_q, grid_depth_q;
  logic [INV_W-1:0]         inv_scale_x_q, inv_scale_z_q;
  logic signed [GAIN_W-1:0] height_gain_q;

  logic [SIZE_W-1:0]        w_size, d_size;
  gpos_t                    pos_x, pos_z, pos_x_q, pos_z_q;
  logic                     in_xfer, query_load, mem_we;
  logic                     out_load;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic signed [HEIGHT_W-1:0] rdata;
  logic signed [OUT_W-1:0]  result;
  blend_ctl_t               bctl;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign query_load  = in_xfer && (in_i.mode == MODE_QUERY);
  assign mem_we      = in_xfer && (in_i.mode == MODE_WRITE)
                       && (32'(in_i.cell_column) < MAX_COLUMNS)
                       && (32'(in_i.cell_row) < MAX_ROWS);
  assign waddr       = cell_addr(IDX_W'(in_i.cell_row), IDX_W'(in_i.cell_column));
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  assign out_o.valid          = out_valid_q;
  assign out_o.sampled_height = out_height_q;

  assign w_size = clamp_size(grid_width_q, MAX_COLUMNS);
  assign d_size = clamp_size(grid_depth_q, MAX_ROWS);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_W'(MAX_COLUMNS);
      grid_depth_q  <= GRID_W'(MAX_ROWS);
      inv_scale_x_q <= INV_W'(256);
      inv_scale_z_q <= INV_W'(256);
      height_gain_q <= GAIN_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[GRID_W-1:0];
        CFG_GRID_DEPTH:  grid_depth_q  <= cfg_wdata_i[GRID_W-1:0];
        CFG_INV_SCALE_X: inv_scale_x_q <= cfg_wdata_i[INV_W-1:0];
        CFG_INV_SCALE_Z: inv_scale_z_q <= cfg_wdata_i[INV_W-1:0];
        CFG_HEIGHT_GAIN: height_gain_q <= $signed(cfg_wdata_i[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  hbs_grid_pos u_pos_x (
    .clk_i   (clk_i),
    .load_i  (query_load),
    .world_i (in_i.world_x),
    .inv_i   (inv_scale_x_q),
    .size_i  (w_size),
    .pos_o   (pos_x)
  );

  hbs_grid_pos u_pos_z (
    .clk_i   (clk_i),
    .load_i  (query_load),
    .world_i (in_i.world_z),
    .inv_i   (inv_scale_z_q),
    .size_i  (d_size),
    .pos_o   (pos_z)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_POS) begin
      pos_x_q <= pos_x;
      pos_z_q <= pos_z;
    end
  end

  always_comb begin
    unique case (state_q)
      S_RD1:   raddr = cell_addr(pos_z_q.idx, pos_x_q.idx1);
      S_RD2:   raddr = cell_addr(pos_z_q.idx1, pos_x_q.idx);
      S_RD3:   raddr = cell_addr(pos_z_q.idx1, pos_x_q.idx1);
      default: raddr = cell_addr(pos_z_q.idx, pos_x_q.idx);
    endcase
  end

  hbs_height_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (in_i.cell_height),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    bctl = '0;
    unique case (state_q)
      S_RD1:   begin bctl.cap_en = 1'b1; bctl.cap_sel = 2'd0; end
      S_RD2:   begin bctl.cap_en = 1'b1; bctl.cap_sel = 2'd1; end
      S_RD3:   begin bctl.cap_en = 1'b1; bctl.cap_sel = 2'd2; end
      S_CAP:   begin bctl.cap_en = 1'b1; bctl.cap_sel = 2'd3; end
      S_ROW:   bctl.row_en  = 1'b1;
      S_MIX:   bctl.mix_en  = 1'b1;
      S_GAIN:  bctl.gain_en = 1'b1;
      default: ;
    endcase
  end

  hbs_blend u_blend (
    .clk_i    (clk_i),
    .ctl_i    (bctl),
    .rdata_i  (rdata),
    .fx_i     (pos_x_q.frac),
    .fz_i     (pos_z_q.frac),
    .gain_i   (height_gain_q),
    .result_o (result)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      out_height_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_height_q <= result;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (query_load) begin
            state_q <= S_POS;
          end
        end
        S_POS:  state_q <= S_RD0;
        S_RD0:  state_q <= S_RD1;
        S_RD1:  state_q <= S_RD2;
        S_RD2:  state_q <= S_RD3;
        S_RD3:  state_q <= S_CAP;
        S_CAP:  state_q <= S_ROW;
        S_ROW:  state_q <= S_MIX;
        S_MIX:  state_q <= S_GAIN;
        S_GAIN: state_q <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_load |=> (state_q == S_POS))
    else $error("query transfer did not start the sequencer");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result appeared outside the output step");

  a_far_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1) |-> ((SIZE_W'(pos_x_q.idx1) < w_size)
                            && (SIZE_W'(pos_z_q.idx1) < d_size)))
    else $error("far neighbour outside the grid in use");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !mem_we)
    else $error("height write while a query is in flight");

endmodule
